[hw/rtl/tef_pkg.sv]
`default_nettype none

package tef_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int LW_W      = 11;
	localparam int WC_W      = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;
	localparam int ROW_W     = 16;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int LINE_W    = 2 * PIX_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 11;
	localparam int MIN_WIDTH = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_EDGE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd3;

	localparam logic [8:0]       EDGE_RST  = 9'd1;
	localparam logic [9:0]       BAND_RST  = 10'd0;
	localparam logic [CH_W-1:0]  BIAS_RST  = 8'd127;
	localparam logic [LW_W-1:0]  WIDTH_RST = 11'd640;

	localparam logic [9:0] RECIP3    = 10'd683;
	localparam int         RECIP3_SH = 11;

	localparam logic [CH_W-1:0] Q_250 = 8'd250;
	localparam logic [CH_W-1:0] Q_200 = 8'd200;
	localparam logic [CH_W-1:0] Q_150 = 8'd150;
	localparam logic [CH_W-1:0] Q_100 = 8'd100;
	localparam logic [CH_W-1:0] Q_50  = 8'd50;

	typedef enum logic [1:0] {
		REG_PASS  = 2'd0,
		REG_BAND  = 2'd1,
		REG_EDGE  = 2'd2,
		REG_QUANT = 2'd3
	} region_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [8:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic x_zero;
		logic x_one;
		logic y_ge1;
		logic y_ge2;
		logic y_eq1;
		logic y_eq2;
	} pos_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
		region_t         region;
	} res_t;

	function automatic logic [CH_W-1:0] quantize(input logic [CH_W-1:0] v);
		logic [CH_W-1:0] q;
		if (v > Q_250) q = Q_250;
		else if (v > Q_200) q = Q_200;
		else if (v > Q_150) q = Q_150;
		else if (v > Q_100) q = Q_100;
		else if (v > Q_50) q = Q_50;
		else q = '0;
		return q;
	endfunction

	function automatic logic [CH_W-1:0] clamp255(input logic signed [12:0] v);
		logic [CH_W-1:0] c;
		if (v < 13'sd0) c = '0;
		else if (v > 13'sd255) c = 8'd255;
		else c = v[CH_W-1:0];
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/tef_ram.sv]
`default_nettype none

module tef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tef_window.sv]
`default_nettype none

module tef_window (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic [tef_pkg::COL_W-1:0] in_x,
	input  wire tef_pkg::pos_t             in_pos,
	input  wire tef_pkg::pix_t             in_pix,
	input  wire logic                      in_pad,
	output logic                           win_valid,
	output tef_pkg::win_t                  win
);

	import tef_pkg::*;

	logic              valid_s1;
	logic [COL_W-1:0]  x_s1;
	pos_t              pos_s1;
	pix_t              pix_s1;
	logic              pad_s1;
	logic              fwd_s1;
	logic [LINE_W-1:0] fwd_data_s1;

	logic [LINE_W-1:0] rdata;
	logic [LINE_W-1:0] rd;
	logic [LINE_W-1:0] wdata;
	pix_t              up_rd;
	pix_t              mid_rd;
	pix_t              pix_eff;
	logic              we;
	logic              emit_pre;
	logic              emit_post;
	pix_t              newcol [3];
	win_t              w_q;
	win_t              p;
	logic              valid_s2;
	win_t              p_s2;

	// Each entry holds the upper line in the high half and the middle line in the low half.
	assign rd      = fwd_s1 ? fwd_data_s1 : rdata;
	assign up_rd   = rd[LINE_W-1:PIX_W];
	assign mid_rd  = rd[PIX_W-1:0];
	assign pix_eff = pad_s1 ? mid_rd : pix_s1;
	assign wdata   = {mid_rd, pix_eff};
	assign we      = en && valid_s1;

	tef_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (we),
		.waddr (x_s1),
		.wdata (wdata),
		.re    (in_valid),
		.raddr (in_x),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && (emit_pre || emit_post);
			if (in_valid) begin
				// The stage one entry is written at this very edge, so its data is passed on.
				fwd_s1 <= valid_s1 && (x_s1 == in_x);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			x_s1        <= in_x;
			pos_s1      <= in_pos;
			pix_s1      <= in_pix;
			pad_s1      <= in_pad;
			fwd_data_s1 <= wdata;
		end
		if (we) begin
			for (int r = 0; r < 3; r++) begin
				w_q[3*r]     <= w_q[3*r + 1];
				w_q[3*r + 1] <= w_q[3*r + 2];
				w_q[3*r + 2] <= newcol[r];
			end
		end
		if (en) begin
			p_s2 <= p;
		end
	end

	assign emit_pre  = pos_s1.x_zero && pos_s1.y_ge2;
	assign emit_post = !pos_s1.x_zero && pos_s1.y_ge1;

	always_comb begin
		int sp;
		int sq;
		newcol[0] = up_rd;
		newcol[1] = mid_rd;
		newcol[2] = pix_eff;
		p = '0;
		for (int r = 0; r < 3; r++) begin
			sp = (r == 0 && pos_s1.y_eq2) ? 1 : r;
			sq = (r == 0 && pos_s1.y_eq1) ? 1 : r;
			if (pos_s1.x_zero) begin
				p[3*r]     = w_q[3*sp + 1];
				p[3*r + 1] = w_q[3*sp + 2];
				p[3*r + 2] = w_q[3*sp + 2];
			end else begin
				p[3*r]     = pos_s1.x_one ? w_q[3*sq + 2] : w_q[3*sq + 1];
				p[3*r + 1] = w_q[3*sq + 2];
				p[3*r + 2] = newcol[sq];
			end
		end
	end

	assign win_valid = valid_s2;
	assign win       = p_s2;

endmodule

`default_nettype wire

[hw/rtl/tef_shade.sv]
`default_nettype none

module tef_shade (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     win_valid,
	input  wire tef_pkg::win_t            win,
	input  wire logic signed [8:0]        edge_threshold,
	input  wire logic signed [9:0]        band_offset,
	input  wire logic [tef_pkg::CH_W-1:0] bias,
	output logic                          res_valid,
	output tef_pkg::res_t                 res
);

	import tef_pkg::*;

	logic               valid_s3;
	logic               valid_s4;
	logic signed [11:0] l_d   [3];
	logic        [11:0] n_d   [3];
	logic signed [11:0] l_s3  [3];
	logic        [11:0] n_s3  [3];
	pix_t               ctr_s3;
	logic [CH_W-1:0]    r_d   [3];
	logic [CH_W-1:0]    d_d   [3];
	logic [CH_W-1:0]    r_s4  [3];
	logic [CH_W-1:0]    d_s4  [3];
	logic [9:0]         sum_d;
	logic [9:0]         sum_s4;
	pix_t               ctr_s4;
	logic [19:0]        prod;
	logic signed [11:0] prom;
	logic signed [11:0] edge_x;
	logic signed [11:0] band_x;
	region_t            reg_c;
	logic [CH_W-1:0]    o [3];

	always_comb begin
		logic [10:0] pos;
		logic [10:0] neg;
		for (int c = 0; c < 3; c++) begin
			pos = 11'(win[5][CH_W*c +: CH_W]) + 11'(win[6][CH_W*c +: CH_W])
				+ {2'b0, win[7][CH_W*c +: CH_W], 1'b0} + 11'(win[8][CH_W*c +: CH_W]);
			neg = 11'(win[0][CH_W*c +: CH_W]) + {2'b0, win[1][CH_W*c +: CH_W], 1'b0}
				+ 11'(win[2][CH_W*c +: CH_W]) + 11'(win[3][CH_W*c +: CH_W]);
			l_d[c] = $signed({1'b0, pos}) - $signed({1'b0, neg});
			n_d[c] = 12'(pos) + 12'(neg) - 12'(win[7][CH_W*c +: CH_W])
				- 12'(win[1][CH_W*c +: CH_W]) + 12'(win[4][CH_W*c +: CH_W]);
		end
	end

	always_comb begin
		logic signed [12:0] lb;
		logic signed [12:0] db;
		sum_d = '0;
		for (int c = 0; c < 3; c++) begin
			lb = 13'(l_s3[c]) + $signed({5'b0, bias});
			db = 13'(l_s3[c]) - $signed({1'b0, n_s3[c]}) + $signed({5'b0, bias});
			r_d[c] = clamp255(lb);
			d_d[c] = clamp255(db);
			sum_d  = sum_d + 10'(r_d[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= win_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s3   <= l_d;
			n_s3   <= n_d;
			ctr_s3 <= win[4];
			r_s4   <= r_d;
			d_s4   <= d_d;
			sum_s4 <= sum_d;
			ctr_s4 <= ctr_s3;
		end
	end

	// Division by three of a sum below 768 as a multiply by the reciprocal.
	assign prod   = sum_s4 * RECIP3;
	assign prom   = $signed({4'b0, prod[RECIP3_SH +: CH_W]});
	assign edge_x = 12'(edge_threshold);
	assign band_x = 12'(edge_threshold) + 12'(band_offset);

	always_comb begin
		if (prom <= edge_x) reg_c = REG_PASS;
		else if (prom < band_x) reg_c = REG_BAND;
		else if (prom == band_x) reg_c = REG_EDGE;
		else reg_c = REG_QUANT;
		for (int c = 0; c < 3; c++) begin
			case (reg_c)
				REG_BAND:  o[c] = quantize(d_s4[c]);
				REG_QUANT: o[c] = quantize(r_s4[c]);
				default:   o[c] = ctr_s4[CH_W*c +: CH_W];
			endcase
		end
	end

	assign res_valid  = valid_s4;
	assign res.blue   = o[0];
	assign res.green  = o[1];
	assign res.red    = o[2];
	assign res.region = reg_c;

endmodule

`default_nettype wire

[hw/rtl/toon_edge_quantize_filter_unit.sv]
`default_nettype none

// Channel   Beat moved                            Handshake
// pix       blue_in green_in red_in frame_start    pix_valid / pix_ready
//           pad_item
// res       blue_out green_out red_out region      res_valid / res_ready
// cfg       cfg_index cfg_data                     cfg_we
//
// One pixel beat is taken every clock while pix_ready is high; the line store is one RAM
// read and written once per beat. Results pass stages s1 to s4, then the output register.
// Reset clears control state only; the line store holds no valid data until a full row is in.
// A stalled result port fills the output and skid registers; then pix_ready drops.

module toon_edge_quantize_filter_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tef_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire logic                          pix_valid,
	output logic                               pix_ready,
	input  wire logic [7:0]                    blue_in,
	input  wire logic [7:0]                    green_in,
	input  wire logic [7:0]                    red_in,
	input  wire logic                          frame_start,
	input  wire logic                          pad_item,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic [7:0]                         blue_out,
	output logic [7:0]                         green_out,
	output logic [7:0]                         red_out,
	output logic [1:0]                         region
);

	import tef_pkg::*;

	logic signed [8:0] edge_q;
	logic signed [9:0] band_q;
	logic [CH_W-1:0]   bias_q;
	logic [LW_W-1:0]   width_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  x;
	logic [ROW_W-1:0]  y;
	logic [WC_W-1:0]   lw_ext;
	logic [WC_W-1:0]   w_eff;
	logic              row_end;
	pos_t              pos;

	logic              adv;
	logic              accept;
	logic              win_valid;
	win_t              win;
	logic              sh_valid;
	res_t              sh_res;

	logic              out_valid_q;
	res_t              out_q;
	logic              skid_valid_q;
	res_t              skid_q;
	logic              out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q  <= EDGE_RST;
			band_q  <= BAND_RST;
			bias_q  <= BIAS_RST;
			width_q <= WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EDGE:  edge_q  <= cfg_data[8:0];
				CFG_BAND:  band_q  <= cfg_data[9:0];
				CFG_BIAS:  bias_q  <= cfg_data[CH_W-1:0];
				CFG_WIDTH: width_q <= cfg_data[LW_W-1:0];
				default:   ;
			endcase
		end
	end

	assign adv       = !skid_valid_q;
	assign pix_ready = adv;
	assign accept    = pix_valid && adv;

	assign x      = frame_start ? '0 : col_q;
	assign y      = frame_start ? '0 : row_q;
	assign lw_ext = WC_W'(width_q);

	always_comb begin
		if (lw_ext < WC_W'(MIN_WIDTH)) w_eff = WC_W'(MIN_WIDTH);
		else if (lw_ext > WC_W'(MAX_WIDTH)) w_eff = WC_W'(MAX_WIDTH);
		else w_eff = lw_ext;
	end

	assign row_end    = (WC_W'(x) + WC_W'(1)) >= w_eff;
	assign pos.x_zero = (x == '0);
	assign pos.x_one  = (x == COL_W'(1));
	assign pos.y_ge1  = (y != '0);
	assign pos.y_ge2  = (y > ROW_W'(1));
	assign pos.y_eq1  = (y == ROW_W'(1));
	assign pos.y_eq2  = (y == ROW_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= (y == '1) ? y : y + ROW_W'(1);
			end else begin
				col_q <= x + COL_W'(1);
				row_q <= y;
			end
		end
	end

	tef_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (accept),
		.in_x      (x),
		.in_pos    (pos),
		.in_pix    ({red_in, green_in, blue_in}),
		.in_pad    (pad_item),
		.win_valid (win_valid),
		.win       (win)
	);

	tef_shade u_shade (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (adv),
		.win_valid      (win_valid),
		.win            (win),
		.edge_threshold (edge_q),
		.band_offset    (band_q),
		.bias           (bias_q),
		.res_valid      (sh_valid),
		.res            (sh_res)
	);

	assign out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= sh_valid;
			end
		end else if (adv && sh_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : sh_res;
		end else if (adv && sh_valid) begin
			skid_q <= sh_res;
		end
	end

	assign res_valid = out_valid_q;
	assign blue_out  = out_q.blue;
	assign green_out = out_q.green;
	assign red_out   = out_q.red;
	assign region    = out_q.region;

endmodule

`default_nettype wire
